// ===== rtl/stls_pkg.sv =====
// static tls allocator package: status codes, command codes, shared types
// no dependencies
package stls_pkg;

   localparam int MaxModulesDefault = 64;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_BAD_ID      = 4'd1,
      ST_BAD_SIZE    = 4'd2,
      ST_BAD_ALIGN   = 4'd3,
      ST_OVERFLOW    = 4'd4,
      ST_RESERVATION = 4'd5,
      ST_ORDER       = 4'd6,
      ST_CONFLICT    = 4'd7,
      ST_NOT_FOUND   = 4'd8,
      ST_FULL        = 4'd9
   } status_type;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_FIND     = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic        find;
      logic        pre_fail;
      status_type  pre_status;
      logic [63:0] key;
      logic [63:0] size;
      logic [63:0] align;
      logic [5:0]  align_log;
      logic [63:0] mask;
      logic [62:0] bias;
   } work_type;

endpackage

// ===== rtl/stls_front.sv =====
// front stage: accepts request items, validates and classifies them
// depends on stls_pkg
module stls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [63:0]       req_module_key,
   input  logic [63:0]       req_block_size,
   input  logic [63:0]       req_align_req,
   input  logic [63:0]       req_align_bias,
   output logic              q_valid,
   input  logic              q_take,
   output stls_pkg::work_type q_data
);
   import stls_pkg::*;

   localparam int Depth = 2;

   work_type   fifo_ff [Depth];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   work_type   cls;
   logic [63:0] al, m;
   logic        push, pop;

   always_comb begin
      al = (req_align_req == 64'd0) ? 64'd1 : req_align_req;
      m  = al - 64'd1;
      cls = '0;
      cls.find  = (req_cmd == CMD_FIND);
      cls.key   = req_module_key;
      cls.size  = req_block_size;
      cls.align = al;
      cls.mask  = m;
      cls.bias  = req_align_bias[62:0] & m[62:0];
      for (int i = 0; i < 64; i++) begin
         if (al[i]) cls.align_log = 6'(i);
      end
      cls.pre_status = ST_OK;
      if (!cls.find) begin
         priority if (req_module_key == 64'd0) begin
            cls.pre_fail = 1'b1; cls.pre_status = ST_BAD_ID;
         end else if (req_block_size == 64'd0) begin
            cls.pre_fail = 1'b1; cls.pre_status = ST_BAD_SIZE;
         end else if ((al & m) != 64'd0) begin
            cls.pre_fail = 1'b1; cls.pre_status = ST_BAD_ALIGN;
         end else begin
            cls.pre_fail = 1'b0;
         end
      end
   end

   assign req_stall = (cnt_ff == 2'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_data    = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/stls_back.sv =====
// back stage: table search, allocation, result register
// depends on stls_pkg
module stls_back #(
   parameter int MaxModules = stls_pkg::MaxModulesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [63:0]        reservation_limit,
   input  logic               q_valid,
   output logic               q_take,
   input  stls_pkg::work_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic [63:0]        rsp_entry_size,
   output logic [63:0]        rsp_entry_align,
   output logic [62:0]        rsp_entry_bias,
   output logic [63:0]        rsp_entry_offset,
   output logic [63:0]        rsp_layout_total,
   output logic [63:0]        rsp_largest_align,
   output logic [6:0]         rsp_entry_count
);
   import stls_pkg::*;

   localparam int AW = (MaxModules > 1) ? $clog2(MaxModules) : 1;
   localparam int CW = $clog2(MaxModules + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CMP   = 6'b000100,
      S_LAST  = 6'b001000,
      S_ALLOC = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   logic [63:0] id_mem   [MaxModules];
   logic [63:0] size_mem [MaxModules];
   logic [5:0]  alog_mem [MaxModules];
   logic [62:0] bias_mem [MaxModules];
   logic [63:0] off_mem  [MaxModules];

   state_type   state_ff, state_in;
   work_type    w_ff;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;
   logic [63:0] total_ff, total_in, maxal_ff, maxal_in;
   logic [63:0] rid_ff, rsz_ff, roff_ff;
   logic [5:0]  ral_ff;
   logic [62:0] rbias_ff;
   logic [63:0] sum_ff, sum_in, cand_ff, cand_in;
   logic        ovf_ff, ovf_in;
   logic [3:0]  st_ff, st_in;
   logic        hit_ff, hit_in;
   logic [AW-1:0] rd_addr;
   logic        wr_en;
   logic        vld_ff, vld_in;
   logic [63:0] o_size_ff, o_align_ff, o_off_ff, o_size_in, o_align_in, o_off_in;
   logic [62:0] o_bias_ff, o_bias_in;
   logic [63:0] rem, off;
   logic [64:0] s1;

   assign q_take = (state_ff == S_IDLE) && q_valid && !vld_ff;

   // last stored id stays on the read port through the allocation cycles
   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      if (state_ff == S_LAST || state_ff == S_ALLOC) rd_addr = AW'(count_ff - CW'(1));
   end

   // one table read per cycle
   always_ff @(posedge clock) begin
      rid_ff   <= id_mem[rd_addr];
      rsz_ff   <= size_mem[rd_addr];
      ral_ff   <= alog_mem[rd_addr];
      rbias_ff <= bias_mem[rd_addr];
      roff_ff  <= off_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[count_ff[AW-1:0]]   <= w_ff.key;
         size_mem[count_ff[AW-1:0]] <= w_ff.size;
         alog_mem[count_ff[AW-1:0]] <= w_ff.align_log;
         bias_mem[count_ff[AW-1:0]] <= w_ff.bias;
         off_mem[count_ff[AW-1:0]]  <= off;
      end
   end

   always_comb begin
      rem = ((cand_ff & w_ff.mask) + {1'b0, w_ff.bias}) & w_ff.mask;
      off = cand_ff - rem;
      s1  = {1'b0, total_ff} + {1'b0, w_ff.size};
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      total_in = total_ff;
      maxal_in = maxal_ff;
      sum_in   = sum_ff;
      cand_in  = cand_ff;
      ovf_in   = ovf_ff;
      st_in    = st_ff;
      hit_in   = hit_ff;
      wr_en    = 1'b0;
      vld_in   = vld_ff && rsp_stall;
      o_size_in  = o_size_ff;
      o_align_in = o_align_ff;
      o_bias_in  = o_bias_ff;
      o_off_in   = o_off_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_take) begin
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = q_data.pre_fail ? S_OUT : S_READ;
               st_in    = q_data.pre_status;
               if (count_ff == '0 && !q_data.pre_fail) state_in = S_LAST;
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            // compare entry read last cycle
            if (rid_ff == w_ff.key) begin
               hit_in   = 1'b1;
               st_in    = ST_OK;
               if (!w_ff.find && (rsz_ff != w_ff.size || ral_ff != w_ff.align_log ||
                                   rbias_ff != w_ff.bias))
                  st_in = ST_CONFLICT;
               o_size_in  = rsz_ff;
               o_align_in = 64'd1 << ral_ff;
               o_bias_in  = rbias_ff;
               o_off_in   = roff_ff;
               state_in   = S_OUT;
            end else if (idx_ff + CW'(1) >= count_ff) begin
               state_in = S_LAST;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_READ;
            end
         end
         S_LAST: begin
            // overflow sums; last id is read in this cycle
            sum_in   = s1[63:0];
            ovf_in   = s1[64];
            state_in = S_ALLOC;
            idx_in   = '0;
         end
         S_ALLOC: begin
            if (idx_ff == '0) begin
               {ovf_in, cand_in} = {ovf_ff, 64'd0} | ({1'b0, sum_ff} + {1'b0, w_ff.mask});
               idx_in = CW'(1);
            end else begin
               state_in = S_OUT;
               if (w_ff.find) st_in = ST_NOT_FOUND;
               else if (count_ff != '0 && w_ff.key <= rid_ff) st_in = ST_ORDER;
               else if (ovf_ff) st_in = ST_OVERFLOW;
               else if (off > reservation_limit) st_in = ST_RESERVATION;
               else if (count_ff >= CW'(MaxModules)) st_in = ST_FULL;
               else begin
                  st_in = ST_OK;
                  hit_in = 1'b1;
                  wr_en = 1'b1;
                  count_in = count_ff + CW'(1);
                  total_in = off;
                  if (w_ff.align > maxal_ff) maxal_in = w_ff.align;
                  o_size_in  = w_ff.size;
                  o_align_in = w_ff.align;
                  o_bias_in  = w_ff.bias;
                  o_off_in   = off;
               end
            end
         end
         S_OUT: begin
            if (!hit_ff) begin
               o_size_in = '0; o_align_in = '0; o_bias_in = '0; o_off_in = '0;
            end
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_take) w_ff <= q_data;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      cand_ff <= cand_in;
      ovf_ff  <= ovf_in;
      st_ff   <= st_in;
      hit_ff  <= hit_in;
      o_size_ff  <= o_size_in;
      o_align_ff <= o_align_in;
      o_bias_ff  <= o_bias_in;
      o_off_ff   <= o_off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         maxal_ff <= 64'd1;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         maxal_ff <= maxal_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_status        = st_ff;
   assign rsp_entry_size    = o_size_ff;
   assign rsp_entry_align   = o_align_ff;
   assign rsp_entry_bias    = o_bias_ff;
   assign rsp_entry_offset  = o_off_ff;
   assign rsp_layout_total  = total_ff;
   assign rsp_largest_align = maxal_ff;
   assign rsp_entry_count   = 7'(count_ff);
endmodule

// ===== rtl/static_tls_offset_allocator.sv =====
// static tls offset allocator top level: csr register, front and back stages
// depends on stls_pkg, stls_front, stls_back
//
//   channel | direction | handshake
//   req_    | in        | req_valid / req_stall
//   rsp_    | out       | rsp_valid / rsp_stall
//   csr_    | in        | csr_write_enable, no stall
//
// an item walks the stored entries in the back stage, one table read per cycle, each
// entry taking a read and a compare state; a hit goes to the out state, else the last and
// alloc states follow. items failing the id, size or alignment checks go straight to out.
// reset is synchronous and active high; table contents are not cleared. the front queue
// holds two items, so requests are taken while the back stage works or a result waits.
module static_tls_offset_allocator #(
   parameter int MaxModules = stls_pkg::MaxModulesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [63:0] req_module_key,
   input  logic [63:0] req_block_size,
   input  logic [63:0] req_align_req,
   input  logic [63:0] req_align_bias,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [63:0] rsp_entry_size,
   output logic [63:0] rsp_entry_align,
   output logic [62:0] rsp_entry_bias,
   output logic [63:0] rsp_entry_offset,
   output logic [63:0] rsp_layout_total,
   output logic [63:0] rsp_largest_align,
   output logic [6:0]  rsp_entry_count
);
   import stls_pkg::*;

   logic [63:0] limit_ff;
   logic        q_valid, q_take;
   work_type    q_data;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= '0;
      else if (csr_write_enable) limit_ff <= csr_write_data;
   end

   stls_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_module_key,
      .req_block_size, .req_align_req, .req_align_bias,
      .q_valid, .q_take, .q_data
   );

   stls_back #(.MaxModules(MaxModules)) u_back (
      .clock, .reset, .reservation_limit(limit_ff), .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_entry_size, .rsp_entry_align,
      .rsp_entry_bias, .rsp_entry_offset, .rsp_layout_total, .rsp_largest_align,
      .rsp_entry_count
   );
endmodule

// ===== rtl/stls_checker.sv =====
// port-level checker for the static tls offset allocator, bound to the top
// depends on static_tls_offset_allocator ports only
module stls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic [63:0] rsp_entry_align,
   input logic [63:0] rsp_largest_align,
   input logic [6:0]  rsp_entry_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("rsp dropped while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 4'd9)
      else $error("bad status");

   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_largest_align))
      else $error("largest align not power of two");

   a_entry_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_align == 64'd0 || $onehot(rsp_entry_align))
      else $error("entry align not power of two");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count >= $past(rsp_entry_count) ||
                    rsp_entry_count == 7'd0)
      else $error("count went down");
endmodule

bind static_tls_offset_allocator stls_checker u_stls_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_status, .rsp_entry_align,
   .rsp_largest_align, .rsp_entry_count
);
